>>> rtl/text_codepoint_decoder_defines.svh
// Assertion helpers for the text code point decoder.
`ifndef TEXT_CODEPOINT_DECODER_DEFINES_SVH
`define TEXT_CODEPOINT_DECODER_DEFINES_SVH

`ifndef SYNTH
`define TCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define TCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/tcd_pkg.sv
`default_nettype none

package tcd_pkg;

    typedef enum logic [1:0] {
        MODE_LATIN1 = 2'd0,
        MODE_UTF8   = 2'd1,
        MODE_UTF16  = 2'd2,
        MODE_UTF32  = 2'd3
    } enc_mode_t;

    typedef struct packed {
        logic [31:0] codepoint;
        logic        run_last;
        logic        text_done;
    } result_t;

    localparam int unsigned FifoDepth = 4;

    // (0xD800 << 10) - 0x10000 + 0xDC00
    localparam logic [31:0] SurrogateBias = 32'h035F_DC00;
    localparam logic [5:0]  HighSurTag    = 6'b110110;
    localparam logic [5:0]  LowSurTag     = 6'b110111;
    localparam logic [2:0]  MaxClass      = 3'd5;

    function automatic logic [2:0] lead_class(input logic [7:0] b);
        logic [2:0] c;
        if (b < 8'hC0)      c = 3'd0;
        else if (b < 8'hE0) c = 3'd1;
        else if (b < 8'hF0) c = 3'd2;
        else if (b < 8'hF8) c = 3'd3;
        else if (b < 8'hFC) c = 3'd4;
        else                c = 3'd5;
        return c;
    endfunction

    function automatic logic [31:0] class_offset(input logic [2:0] c);
        logic [31:0] o;
        case (c)
            3'd1:    o = 32'h0000_3080;
            3'd2:    o = 32'h000E_2080;
            3'd3:    o = 32'h03C8_2080;
            3'd4:    o = 32'hFA08_2080;
            3'd5:    o = 32'h8208_2080;
            default: o = 32'h0000_0000;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/text_codepoint_decoder.sv
// Text code point decoder. Takes one code unit per beat (Latin-1, UTF-8, UTF-16 or
// UTF-32, chosen by the 2-bit encoding mode register, reset UTF-8) and returns
// 0 to 2 code points per unit. One unit is accepted every clock as long as the
// 4-entry result queue has room for two results; decode is a single combinational
// pass from the input beat into the queue, so a unit's first result is visible on
// m_* the cycle after it is accepted if the queue was empty. Sustained rate is one
// unit per cycle while results are taken every cycle; only the UTF-16 unpaired
// high surrogate case emits two results for one unit. Writing the mode register
// drops any partly decoded sequence; write it only while the block is idle.
`default_nettype none

`include "text_codepoint_decoder_defines.svh"

module text_codepoint_decoder
    import tcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_encoding_mode,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_code_unit,
    input  wire logic        s_unit_is_final,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_codepoint,
    output logic             m_run_last,
    output logic             m_text_done
);

    localparam int unsigned PtrW = $clog2(FifoDepth);
    localparam int unsigned CntW = $clog2(FifoDepth + 1);

    enc_mode_t       mode_reg;
    logic [31:0]     partial_reg, partial_next;
    logic [2:0]      bytes_left_reg, bytes_left_next;
    logic [2:0]      seq_class_reg, seq_class_next;
    logic            sur_pend_reg, sur_pend_next;

    result_t         fifo_reg [FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;

    logic            cfg_accept, s_accept, m_pop;
    logic [1:0]      n_res;
    result_t         res0, res1;

    logic [7:0]      b;
    logic [31:0]     b32;
    logic [2:0]      lc, cls_c;
    logic [15:0]     u;
    logic [31:0]     u32;
    logic            is_high, is_low;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_ready    = (cnt_reg <= CntW'(FifoDepth - 2));
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = (cnt_reg != '0);
    assign m_pop      = m_valid && m_ready;

    assign m_codepoint = fifo_reg[rd_ptr_reg].codepoint;
    assign m_run_last  = fifo_reg[rd_ptr_reg].run_last;
    assign m_text_done = fifo_reg[rd_ptr_reg].text_done;

    assign b       = s_code_unit[7:0];
    assign b32     = {24'd0, b};
    assign lc      = lead_class(b);
    assign cls_c   = (seq_class_reg > MaxClass) ? MaxClass : seq_class_reg;
    assign u       = s_code_unit[15:0];
    assign u32     = {16'd0, u};
    assign is_high = (u[15:10] == HighSurTag);
    assign is_low  = (u[15:10] == LowSurTag);

    always_comb begin
        partial_next    = partial_reg;
        bytes_left_next = bytes_left_reg;
        seq_class_next  = seq_class_reg;
        sur_pend_next   = sur_pend_reg;
        n_res           = 2'd0;
        res0            = '{codepoint: s_code_unit, run_last: 1'b1,
                            text_done: s_unit_is_final};
        res1            = res0;

        unique case (mode_reg)
            MODE_LATIN1: begin
                res0.codepoint = b32;
                n_res          = 2'd1;
            end
            MODE_UTF32: begin
                n_res = 2'd1;
            end
            MODE_UTF8: begin
                if (seq_class_reg == 3'd0) begin
                    if (lc == 3'd0 || s_unit_is_final) begin
                        res0.codepoint = b32 - class_offset(lc);
                        n_res          = 2'd1;
                    end else begin
                        partial_next    = {18'd0, b, 6'd0};
                        bytes_left_next = lc - 3'd1;
                        seq_class_next  = lc;
                    end
                end else if (bytes_left_reg != 3'd0 && !s_unit_is_final) begin
                    partial_next    = (partial_reg + b32) << 6;
                    bytes_left_next = bytes_left_reg - 3'd1;
                end else begin
                    res0.codepoint  = partial_reg + b32 - class_offset(cls_c);
                    n_res           = 2'd1;
                    partial_next    = '0;
                    bytes_left_next = '0;
                    seq_class_next  = '0;
                end
            end
            MODE_UTF16: begin
                if (sur_pend_reg && is_low) begin
                    res0.codepoint = (partial_reg << 10) + u32 - SurrogateBias;
                    n_res          = 2'd1;
                    sur_pend_next  = 1'b0;
                    partial_next   = '0;
                end else begin
                    // held high surrogate goes out ahead of the follower; alone if a new high one is held
                    if (is_high && !s_unit_is_final) begin
                        partial_next  = u32;
                        sur_pend_next = 1'b1;
                        if (sur_pend_reg) begin
                            res0  = '{codepoint: partial_reg, run_last: 1'b1,
                                      text_done: 1'b0};
                            n_res = 2'd1;
                        end
                    end else begin
                        sur_pend_next = 1'b0;
                        partial_next  = '0;
                        if (sur_pend_reg) begin
                            res0  = '{codepoint: partial_reg, run_last: 1'b0,
                                      text_done: 1'b0};
                            res1  = '{codepoint: u32, run_last: 1'b1,
                                      text_done: s_unit_is_final};
                            n_res = 2'd2;
                        end else begin
                            res0.codepoint = u32;
                            n_res          = 2'd1;
                        end
                    end
                end
            end
        endcase

        if (s_unit_is_final) begin
            partial_next    = '0;
            bytes_left_next = '0;
            seq_class_next  = '0;
            sur_pend_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_UTF8;
            partial_reg    <= '0;
            bytes_left_reg <= '0;
            seq_class_reg  <= '0;
            sur_pend_reg   <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end else begin
            if (cfg_accept) begin
                mode_reg       <= enc_mode_t'(cfg_encoding_mode);
                partial_reg    <= '0;
                bytes_left_reg <= '0;
                seq_class_reg  <= '0;
                sur_pend_reg   <= 1'b0;
            end else if (s_accept) begin
                partial_reg    <= partial_next;
                bytes_left_reg <= bytes_left_next;
                seq_class_reg  <= seq_class_next;
                sur_pend_reg   <= sur_pend_next;
            end
            if (s_accept) begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(n_res);
            end
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            cnt_reg <= cnt_reg + (s_accept ? CntW'(n_res) : CntW'(0))
                       - CntW'(m_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (s_accept && n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + PtrW'(1)] <= res1;
        end
    end

    `TCD_ASSERT_IMP(a_fifo_bound, aclk, aresetn, 1'b1, cnt_reg <= CntW'(FifoDepth), "result queue overflow")
    `TCD_ASSERT_NXT(a_final_clears, aclk, aresetn, s_accept && s_unit_is_final && !cfg_accept, seq_class_reg == 3'd0 && bytes_left_reg == 3'd0 && !sur_pend_reg, "state not clear after final unit")
    `TCD_ASSERT_IMP(a_utf8_state, aclk, aresetn, seq_class_reg != 3'd0, seq_class_reg <= MaxClass && bytes_left_reg < seq_class_reg, "open UTF-8 sequence inconsistent")
    `TCD_ASSERT_NXT(a_pass_count, aclk, aresetn, s_accept && !m_pop && (mode_reg == MODE_LATIN1 || mode_reg == MODE_UTF32), cnt_reg == $past(cnt_reg) + CntW'(1), "pass-through unit lost")

endmodule

`default_nettype wire
